@@ design/itf_pkg.sv @@
package itf_pkg;

    localparam int ValueWidth  = 64;
    localparam int CharWidth   = 7;
    localparam int CountWidth  = 2;
    localparam int SizeWidth   = 2;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = 7;
    localparam int DefMaxDigits = 64;
    localparam int DefMaxWidth  = 64;
    localparam int LenWidth    = 8;

    localparam logic [1:0] RadixDec = 2'd0;
    localparam logic [1:0] RadixBin = 2'd1;
    localparam logic [1:0] RadixOct = 2'd2;
    localparam logic [1:0] RadixHex = 2'd3;

    localparam logic [2:0] RegRadix  = 3'd0;
    localparam logic [2:0] RegUpper  = 3'd1;
    localparam logic [2:0] RegPlus   = 3'd2;
    localparam logic [2:0] RegPrefix = 3'd3;
    localparam logic [2:0] RegZero   = 3'd4;
    localparam logic [2:0] RegWidth  = 3'd5;

    localparam logic [6:0] ChZero  = 7'h30;
    localparam logic [6:0] ChMinus = 7'h2d;
    localparam logic [6:0] ChPlus  = 7'h2b;
    localparam logic [6:0] ChSpace = 7'h20;
    localparam logic [6:0] ChUpA   = 7'h41;
    localparam logic [6:0] ChLoA   = 7'h61;

    typedef struct packed {
        logic [1:0] radix_mode;
        logic       upper_case;
        logic [1:0] plus_mode;
        logic       prefix_enable;
        logic       zero_pad;
        logic [6:0] min_width;
    } t_cfg;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic emit;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic digits_done;
        logic emit_last;
    } t_sts;

endpackage

@@ design/itf_if.sv @@
interface itf_in_if;
    logic                           valid;
    logic                           ready;
    logic [itf_pkg::ValueWidth-1:0] value;
    logic                           is_signed;
    logic [itf_pkg::SizeWidth-1:0]  operand_size;
    modport source (output valid, value, is_signed, operand_size, input ready);
    modport sink (input valid, value, is_signed, operand_size, output ready);
endinterface

interface itf_out_if;
    logic                           valid;
    logic                           ready;
    logic [itf_pkg::CharWidth-1:0]  first_char;
    logic [itf_pkg::CharWidth-1:0]  second_char;
    logic [itf_pkg::CountWidth-1:0] char_count;
    logic                           last;
    modport source (output valid, first_char, second_char, char_count, last, input ready);
    modport sink (input valid, first_char, second_char, char_count, last, output ready);
endinterface

interface itf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [itf_pkg::CfgIdxWidth-1:0]  index;
    logic [itf_pkg::CfgDataWidth-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/itf_datapath.sv @@
module itf_datapath #(
    parameter int MAX_DIGITS = itf_pkg::DefMaxDigits,
    parameter int MAX_WIDTH  = itf_pkg::DefMaxWidth
) (
    input  logic                           i_clk,
    input  itf_pkg::t_cfg                  i_cfg,
    input  itf_pkg::t_cmd                  i_cmd,
    input  logic [itf_pkg::ValueWidth-1:0] i_value,
    input  logic                           i_is_signed,
    input  logic [itf_pkg::SizeWidth-1:0]  i_operand_size,
    output itf_pkg::t_sts                  o_sts,
    output logic [itf_pkg::CharWidth-1:0]  o_first_char,
    output logic [itf_pkg::CharWidth-1:0]  o_second_char,
    output logic [itf_pkg::CountWidth-1:0] o_char_count,
    output logic                           o_last
);
    import itf_pkg::*;

    localparam int DigW = $clog2(MAX_DIGITS + 1);
    localparam int AdrW = $clog2(MAX_DIGITS);

    logic [ValueWidth-1:0] r_rem, n_rem;
    logic [DigW-1:0]       r_dcnt;
    logic [3:0]            r_store [MAX_DIGITS];
    logic                  r_neg;
    logic [6:0]            r_sign;
    logic                  r_has_sign;
    logic [LenWidth-1:0]   r_pos, r_len;
    logic [LenWidth-1:0]   r_pre_len, r_sign_pos, r_dig_start;
    logic [6:0]            r_pre1;

    logic [ValueWidth-1:0] mask, v_in, quot;
    logic [3:0]            digit;
    logic                  neg_in;
    logic [5:0]            sbit_idx;

    always_comb begin
        case (i_operand_size)
            2'd0:    begin mask = 64'hffff;      sbit_idx = 6'd15; end
            2'd1:    begin mask = 64'hffff_ffff; sbit_idx = 6'd31; end
            default: begin mask = '1;            sbit_idx = 6'd63; end
        endcase
        v_in   = i_value & mask;
        neg_in = i_is_signed & v_in[sbit_idx];
        if (neg_in && i_cfg.radix_mode == RadixDec) begin
            v_in = (~v_in + 64'd1) & mask;
        end
    end

    // Division by ten as a reciprocal multiply split over constant shifts and adds.
    logic [ValueWidth-1:0] q0, q1, q2, q3, q4, q5, r10;
    always_comb begin
        q0 = (r_rem >> 1) + (r_rem >> 2);
        q1 = q0 + (q0 >> 4);
        q2 = q1 + (q1 >> 8);
        q3 = q2 + (q2 >> 16);
        q4 = q3 + (q3 >> 32);
        q5 = q4 >> 3;
        r10 = r_rem - ((q5 << 3) + (q5 << 1));
        if (r10 >= 64'd10) begin
            quot  = q5 + 64'd1;
            digit = 4'(r10 - 64'd10);
        end else begin
            quot  = q5;
            digit = r10[3:0];
        end
        case (i_cfg.radix_mode)
            RadixBin: begin n_rem = r_rem >> 1; digit = {3'd0, r_rem[0]}; end
            RadixOct: begin n_rem = r_rem >> 3; digit = {1'b0, r_rem[2:0]}; end
            RadixHex: begin n_rem = r_rem >> 4; digit = r_rem[3:0]; end
            default:  n_rem = quot;
        endcase
    end

    assign o_sts.digits_done = (r_rem == '0) || (r_dcnt == DigW'(MAX_DIGITS));

    // Layout figures, worked out once after digit generation.
    logic [LenWidth-1:0] f_width, f_body, f_pads, f_pre, f_dc;
    logic                f_sign;
    logic [6:0]          f_sch;
    always_comb begin
        f_dc = (r_dcnt == '0) ? LenWidth'(1) : LenWidth'(r_dcnt);
        f_sign = 1'b0;
        f_sch = ChSpace;
        if (i_cfg.radix_mode == RadixDec) begin
            if (r_neg) begin f_sign = 1'b1; f_sch = ChMinus; end
            else if (i_cfg.plus_mode == 2'd1) begin f_sign = 1'b1; f_sch = ChPlus; end
            else if (i_cfg.plus_mode == 2'd2) begin f_sign = 1'b1; f_sch = ChSpace; end
        end
        f_width = LenWidth'(i_cfg.min_width);
        if (f_width == '0) f_width = LenWidth'(1);
        if (f_width > LenWidth'(MAX_WIDTH)) f_width = LenWidth'(MAX_WIDTH);
        f_body = f_dc + LenWidth'(f_sign);
        f_pads = (f_width > f_body) ? f_width - f_body : '0;
        f_pre = '0;
        if (i_cfg.radix_mode != RadixDec && i_cfg.prefix_enable) begin
            f_pre = (i_cfg.radix_mode == RadixOct) ? LenWidth'(1) : LenWidth'(2);
        end
    end

    function automatic logic [6:0] char_at(input logic [LenWidth-1:0] p,
                                           input logic [3:0] d);
        logic [6:0] c;
        c = ChSpace;
        if (p < r_pre_len) begin
            c = (p == '0) ? ChZero : r_pre1;
        end else if (p < r_dig_start) begin
            if (r_has_sign && p == r_sign_pos) c = r_sign;
            else c = i_cfg.zero_pad ? ChZero : ChSpace;
        end else if (d < 4'd10) begin
            c = ChZero + 7'(d);
        end else begin
            c = (i_cfg.upper_case ? ChUpA : ChLoA) + 7'(d - 4'd10);
        end
        return c;
    endfunction

    logic [LenWidth-1:0] idx0, idx1, p1;
    logic [3:0]          d0, d1;
    always_comb begin
        p1 = r_pos + LenWidth'(1);
        idx0 = r_len - LenWidth'(1) - r_pos;
        idx1 = r_len - LenWidth'(1) - p1;
    end

    always_ff @(posedge i_clk) begin
        d0 <= r_store[idx0[AdrW-1:0]];
        d1 <= r_store[idx1[AdrW-1:0]];
    end

    // Emission registers: r_epos registers r_pos alongside the store read at r_pos.
    logic [LenWidth-1:0] r_epos;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem  <= v_in;
            r_dcnt <= '0;
            r_neg  <= neg_in;
        end
        if (i_cmd.step && !o_sts.digits_done) begin
            r_store[r_dcnt[AdrW-1:0]] <= digit;
            r_dcnt <= r_dcnt + DigW'(1);
            r_rem  <= n_rem;
        end
        if (i_cmd.finish) begin
            if (r_dcnt == '0) begin
                r_store[0] <= 4'd0;
            end
            r_has_sign  <= f_sign;
            r_sign      <= f_sch;
            r_pre_len   <= f_pre;
            r_pre1      <= (i_cfg.radix_mode == RadixBin) ?
                           (i_cfg.upper_case ? 7'h42 : 7'h62) :
                           (i_cfg.upper_case ? 7'h58 : 7'h78);
            r_sign_pos  <= i_cfg.zero_pad ? f_pre : f_pre + f_pads;
            r_dig_start <= f_pre + f_pads + LenWidth'(f_sign);
            r_len       <= f_pre + f_pads + f_body;
            r_pos       <= '0;
        end
        if (i_cmd.emit) begin
            r_pos <= r_pos + LenWidth'(2);
        end
        r_epos <= r_pos;
    end

    logic [LenWidth-1:0] left;
    always_comb begin
        left = r_len - r_epos;
        o_first_char  = char_at(r_epos, d0);
        o_second_char = (left >= LenWidth'(2)) ?
                        char_at(r_epos + LenWidth'(1), d1) : 7'd0;
        o_char_count  = (left >= LenWidth'(2)) ? 2'd2 : 2'd1;
        o_last        = (left <= LenWidth'(2));
    end

    assign o_sts.emit_last = o_last;

endmodule

@@ design/itf_ctrl.sv @@
module itf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  itf_pkg::t_sts i_sts,
    output itf_pkg::t_cmd o_cmd
);
    import itf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIGITS, S_FINISH, S_FETCH, S_SHOW
    } t_state;

    t_state r_state;

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_SHOW);
        o_cmd.load   = o_in_ready & i_in_valid;
        o_cmd.step   = (r_state == S_DIGITS);
        o_cmd.finish = (r_state == S_FINISH);
        o_cmd.emit   = o_out_valid & i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:   if (i_in_valid) r_state <= S_DIGITS;
                S_DIGITS: if (i_sts.digits_done) r_state <= S_FINISH;
                S_FINISH: r_state <= S_FETCH;
                S_FETCH:  r_state <= S_SHOW;
                S_SHOW: begin
                    if (i_out_ready) r_state <= i_sts.emit_last ? S_IDLE : S_FETCH;
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_dual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and valid together");
    a_load_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_DIGITS) else $error("load lost");
    a_show_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_FETCH) else $error("no fetch");
`endif

endmodule

@@ design/integer_to_text_formatter.sv @@
// Flow: the digit phase stores one digit per step until the number is used up or
// MAX_DIGITS digits are held; a layout step follows, then each result word of two
// characters is fetched and shown. One number at a time; each word waits for ready.
// Reset: synchronous active-low; the configuration registers return to their reset
// values and the controller goes idle. Datapath registers are loaded with each number
// and the digit memory is not cleared.
module integer_to_text_formatter #(
    parameter int MAX_DIGITS = itf_pkg::DefMaxDigits,
    parameter int MAX_WIDTH  = itf_pkg::DefMaxWidth
) (
    input logic  i_clk,
    input logic  i_rst_n,
    itf_in_if.sink    i_in,
    itf_out_if.source o_out,
    itf_cfg_if.sink   i_cfg
);
    import itf_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{radix_mode: RadixDec, upper_case: 1'b0, plus_mode: 2'd0,
                       prefix_enable: 1'b0, zero_pad: 1'b0, min_width: 7'd1};
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                RegRadix:  r_cfg.radix_mode    <= i_cfg.data[1:0];
                RegUpper:  r_cfg.upper_case    <= i_cfg.data[0];
                RegPlus:   r_cfg.plus_mode     <= i_cfg.data[1:0];
                RegPrefix: r_cfg.prefix_enable <= i_cfg.data[0];
                RegZero:   r_cfg.zero_pad      <= i_cfg.data[0];
                RegWidth:  r_cfg.min_width     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    itf_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_out_valid(o_out.valid),
        .i_out_ready(o_out.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    itf_datapath #(.MAX_DIGITS(MAX_DIGITS), .MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk,
        .i_cfg         (r_cfg),
        .i_cmd         (cmd),
        .i_value       (i_in.value),
        .i_is_signed   (i_in.is_signed),
        .i_operand_size(i_in.operand_size),
        .o_sts         (sts),
        .o_first_char  (o_out.first_char),
        .o_second_char (o_out.second_char),
        .o_char_count  (o_out.char_count),
        .o_last        (o_out.last)
    );

endmodule
